>>> sv/assert_macros.svh
// assertion macros for checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define FWLL_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked at every edge, reset included
`define FWLL_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/fwll_pkg.sv
`timescale 1ns / 1ps

package fwll_pkg;

    localparam int TIME_W    = 32;
    localparam int CFG_W     = 16;
    localparam int ATT_W     = 7;
    localparam int REM_W     = 16;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [OP_W-1:0] OP_CHECK = 2'd0;
    localparam logic [OP_W-1:0] OP_FAIL  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT = 2'd2;

    localparam logic [CFG_W-1:0] WINDOW_RST  = 16'd300;
    localparam logic [ATT_W-1:0] MAX_ATT_RST = 7'd5;
    localparam logic [CFG_W-1:0] LOCKOUT_RST = 16'd300;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [TIME_W-1:0] now_seconds;
    } in_item_t;

    typedef struct packed {
        logic             locked;
        logic [REM_W-1:0] remaining;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_REPORT
    } state_t;

endpackage

>>> sv/fwll_ring.sv
`timescale 1ns / 1ps

module fwll_ring import fwll_pkg::*; #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [TIME_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [TIME_W-1:0] rd_data
);

    logic [TIME_W-1:0] mem [DEPTH];
    logic [TIME_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/failure_window_lockout_limiter.sv
`timescale 1ns / 1ps

// Failure-window lockout limiter. Each input beat carries an opcode (check,
// record failure, reset) and the current time in seconds; each one gives
// exactly one result beat with the lockout flag and the seconds left. A
// record failure reads the stored timestamps from the ring memory one per
// cycle, then stores the new time, may set the lockout and reports; check,
// reset and unknown opcodes go straight to the report. A new beat is taken
// once the previous one has been placed in the output register. The ring
// needs no clearing pass: a fill count marks which entries are live.
// Configuration writes are taken at any time but should only be issued
// while the block is idle.
module failure_window_lockout_limiter import fwll_pkg::*; #(
    parameter int RING_DEPTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wr_data
);

    localparam int AW   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW   = $clog2(RING_DEPTH + 1);
    localparam int RW   = $clog2(RING_DEPTH + 2);
    localparam int CMPW = (RW > ATT_W) ? RW : ATT_W;
    localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(RING_DEPTH);

    state_t            state_reg, state_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     slot_reg, slot_next;
    logic [TIME_W-1:0] lock_end_reg, lock_end_next;
    logic [CW-1:0]     scan_idx_reg, scan_idx_next;
    logic              rd_valid_reg, rd_valid_next;
    logic [RW-1:0]     recent_reg, recent_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg, out_data_next;

    logic [CFG_W-1:0]  window_reg;
    logic [ATT_W-1:0]  max_att_reg;
    logic [CFG_W-1:0]  lockout_reg;

    logic              mem_we;
    logic              mem_re;
    logic [TIME_W-1:0] mem_rdata;
    logic              hit;
    logic [RW-1:0]     total;
    logic [TIME_W:0]   end_sum;
    logic [TIME_W-1:0] left;

    fwll_ring #(
        .DEPTH (RING_DEPTH),
        .AW    (AW)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (slot_reg),
        .wr_data (now_reg),
        .rd_en   (mem_re),
        .rd_addr (scan_idx_reg[AW-1:0]),
        .rd_data (mem_rdata)
    );

    // recent if stored time is ahead of now or within the window
    assign hit = (mem_rdata > now_reg) ||
                 ((now_reg - mem_rdata) <= {{(TIME_W-CFG_W){1'b0}}, window_reg});
    assign total   = recent_reg + RW'(1);
    assign end_sum = {1'b0, now_reg} + {{(TIME_W-CFG_W+1){1'b0}}, lockout_reg};
    assign left    = lock_end_reg - now_reg;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_comb begin
        state_next     = state_reg;
        now_next       = now_reg;
        count_next     = count_reg;
        slot_next      = slot_reg;
        lock_end_next  = lock_end_reg;
        scan_idx_next  = scan_idx_reg;
        rd_valid_next  = 1'b0;
        recent_next    = recent_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;

        if (m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    now_next      = s_data.now_seconds;
                    scan_idx_next = '0;
                    recent_next   = '0;
                    state_next    = ST_REPORT;
                    priority if (s_data.opcode == OP_FAIL) begin
                        state_next = ST_SCAN;
                    end else if (s_data.opcode == OP_CLEAR ||
                                 (s_data.opcode == OP_CHECK && lock_end_reg != '0 &&
                                  lock_end_reg <= s_data.now_seconds)) begin
                        count_next    = '0;
                        slot_next     = '0;
                        lock_end_next = '0;
                    end else begin
                    end
                end
            end
            ST_SCAN: begin
                if (rd_valid_reg && hit) begin
                    recent_next = recent_reg + RW'(1);
                end
                if (scan_idx_reg != count_reg) begin
                    mem_re        = 1'b1;
                    rd_valid_next = 1'b1;
                    scan_idx_next = scan_idx_reg + CW'(1);
                end else if (!rd_valid_reg) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                mem_we    = 1'b1;
                slot_next = (slot_reg == LAST_SLOT) ? '0 : slot_reg + AW'(1);
                if (count_reg != FULL_CNT) begin
                    count_next = count_reg + CW'(1);
                end
                if (CMPW'(total) >= CMPW'(max_att_reg)) begin
                    lock_end_next = end_sum[TIME_W] ? '1 : end_sum[TIME_W-1:0];
                end
                state_next = ST_REPORT;
            end
            ST_REPORT: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    if (lock_end_reg > now_reg) begin
                        out_data_next.locked    = 1'b1;
                        out_data_next.remaining = (left[TIME_W-1:REM_W] != '0) ?
                                                  '1 : left[REM_W-1:0];
                    end else begin
                        out_data_next.locked    = 1'b0;
                        out_data_next.remaining = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            slot_reg      <= '0;
            lock_end_reg  <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            slot_reg      <= slot_next;
            lock_end_reg  <= lock_end_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg      <= now_next;
        scan_idx_reg <= scan_idx_next;
        recent_reg   <= recent_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg  <= WINDOW_RST;
            max_att_reg <= MAX_ATT_RST;
            lockout_reg <= LOCKOUT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_WINDOW:  window_reg  <= cfg_wr_data;
                CFG_MAX_ATT: max_att_reg <= cfg_wr_data[ATT_W-1:0];
                CFG_LOCKOUT: lockout_reg <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

endmodule

>>> sv/fwll_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fwll_checker import fwll_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    property p_out_hold;
        m_valid && !m_ready |=> m_valid && $stable(m_data);
    endproperty

    property p_in_hold;
        s_valid && !s_ready |=> s_valid && $stable(s_data);
    endproperty

    property p_unlocked_zero;
        m_valid && !m_data.locked |-> m_data.remaining == '0;
    endproperty

    property p_locked_nonzero;
        m_valid && m_data.locked |-> m_data.remaining != '0;
    endproperty

    property p_reset_quiet;
        !aresetn |=> !m_valid;
    endproperty

    // result beat held until taken
    `FWLL_ASSERT(a_out_hold, aclk, aresetn, p_out_hold, "result beat changed while stalled")

    // input beat held until taken
    `FWLL_ASSERT(a_in_hold, aclk, aresetn, p_in_hold, "input beat changed while waiting")

    // unlocked result reports no time left
    `FWLL_ASSERT(a_unlocked_zero, aclk, aresetn, p_unlocked_zero, "remaining nonzero unlocked")

    // locked result reports some time left
    `FWLL_ASSERT(a_locked_nonzero, aclk, aresetn, p_locked_nonzero, "remaining zero while locked")

    // no result beat right after reset
    `FWLL_ASSERT_ALWAYS(a_reset_quiet, aclk, p_reset_quiet, "result beat right after reset")

endmodule

bind failure_window_lockout_limiter fwll_checker u_fwll_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
